@@ design/mwsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwsm_pkg
// Shared widths, constants, types and the quarter-wave sine table of the
// mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
package mwsm_pkg;

  // field and register widths
  localparam int THR_W    = 8;
  localparam int HEAD_W   = 16;
  localparam int MAXSPD_W = 15;
  localparam int GAIN_W   = 12;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 1;

  // datapath widths
  localparam int BASE_W = THR_W + MAXSPD_W;   // throttle * max_speed
  localparam int TRIG_W = 18;                 // +/-32768
  localparam int MULA_W = 19;                 // cos +/- sin, or +/-gain
  localparam int PROD_W = MULA_W + BASE_W;
  localparam int MAG_W  = 25;                 // rounded magnitude over 25
  localparam int QUO_W  = 21;
  localparam int VAL_W  = QUO_W + 2;          // signed value, room for negate

  // heading mod 360: offset by a multiple of 360 so the value is positive
  localparam int X_W              = 17;
  localparam int DEG_W            = 9;
  localparam int Q360_W           = 8;
  localparam logic [X_W-1:0] ANGLE_OFS = 17'd33120;   // 92 * 360
  localparam int RECIP360_W       = 16;
  localparam logic [RECIP360_W-1:0] RECIP360 = 16'd46604; // ceil(2^24/360)
  localparam int RECIP360_SH      = 24;
  localparam logic [X_W-1:0] DEG_360 = 17'd360;
  localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
  localparam logic [DEG_W-1:0] DEG_180 = 9'd180;
  localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
  localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;

  // divide by 100*2^15 (translate) or 100*2^8 (rotate) = 25 * 2^k
  localparam logic [PROD_W-1:0] TRANS_HALF = 42'd1638400;
  localparam int                TRANS_SH   = 17;
  localparam logic [PROD_W-1:0] ROT_HALF   = 42'd12800;
  localparam int                ROT_SH     = 10;
  localparam int RECIP25_W  = 26;
  localparam logic [RECIP25_W-1:0] RECIP25 = 26'd42949673;  // ceil(2^30/25)
  localparam int RECIP25_SH = 30;

  // reset values and defaults
  localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST   = 15'd1000;
  localparam logic [GAIN_W-1:0]   ROTATE_GAIN_RST = 12'd494;
  localparam int                  SPEED_BITS_DEF  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED   = 1'b0,
    CFG_ROTATE_GAIN = 1'b1
  } mwsm_cfg_idx_t;

  localparam logic MODE_TRANSLATE = 1'b0;
  localparam logic MODE_ROTATE    = 1'b1;

  // front end -> multiplier stage
  typedef struct packed {
    logic                     vld;
    logic                     mode;
    logic                     hd_pos;
    logic                     hd_neg;
    logic signed [BASE_W-1:0] base;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } mwsm_trig_t;

  // multiplier stage -> output stage
  typedef struct packed {
    logic             vld;
    logic             mode;
    logic             neg_a;
    logic             neg_b;
    logic [QUO_W-1:0] mag_a;
    logic [QUO_W-1:0] mag_b;
  } mwsm_quo_t;

  localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,
     16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
     16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
     16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668,
    16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
    16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
    16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
    16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
    16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
    16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
    16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
    16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
    16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
    16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
    16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
    16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
    16'd32768
  };

  // signed Q1.15 lookup; idx is already folded into 0..90
  function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [6:0] idx,
                                                            input logic neg);
    logic signed [TRIG_W-1:0] mag;
    mag = (idx <= 7'd90) ? $signed({2'b00, SINE_Q15[idx]}) : '0;
    return neg ? -mag : mag;
  endfunction

endpackage
`default_nettype wire

@@ design/mwsm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwsm_front
// Stages 1-3: drive base product, heading mod 360 and sine/cosine lookup.
// ----------------------------------------------------------------------------
module mwsm_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  input  wire logic                           in_mode,
  input  wire logic signed [mwsm_pkg::THR_W-1:0]  in_throttle,
  input  wire logic signed [mwsm_pkg::HEAD_W-1:0] in_heading,
  input  wire logic [mwsm_pkg::MAXSPD_W-1:0]  max_speed,
  output mwsm_pkg::mwsm_trig_t                trig
);
  import mwsm_pkg::*;

  // stage 1
  logic                     s1_vld_r;
  logic                     s1_mode_r, s1_pos_r, s1_neg_r;
  logic signed [BASE_W-1:0] s1_base_r;
  logic [X_W-1:0]           s1_x_r;
  logic [Q360_W-1:0]        s1_q_r;
  logic [HEAD_W+1:0]        x_sum;
  logic [X_W-1:0]           x_nxt;
  logic [X_W+RECIP360_W-1:0] xq_prod;
  logic signed [BASE_W:0]   base_full;

  assign x_sum     = {{2{in_heading[HEAD_W-1]}}, in_heading} + {1'b0, ANGLE_OFS};
  assign x_nxt     = x_sum[X_W-1:0];
  assign xq_prod   = x_nxt * RECIP360;
  assign base_full = in_throttle * $signed({1'b0, max_speed});

  // stage 2
  logic                     s2_vld_r;
  logic                     s2_mode_r, s2_pos_r, s2_neg_r;
  logic signed [BASE_W-1:0] s2_base_r;
  logic [DEG_W-1:0]         s2_deg_r;
  logic [X_W-1:0]           rem_full;

  assign rem_full = s1_x_r - ({{(X_W-Q360_W){1'b0}}, s1_q_r} * DEG_360);

  // stage 3: quadrant fold
  logic [DEG_W-1:0] sin_idx, cos_idx;
  logic             sin_neg, cos_neg;
  logic signed [TRIG_W-1:0] sin_nxt, cos_nxt;
  logic                     s3_vld_r;
  logic                     s3_mode_r, s3_pos_r, s3_neg_r;
  logic signed [BASE_W-1:0] s3_base_r;
  logic signed [TRIG_W-1:0] s3_sin_r, s3_cos_r;

  always_comb begin
    if (s2_deg_r <= DEG_90) begin
      sin_idx = s2_deg_r;            sin_neg = 1'b0;
      cos_idx = DEG_90 - s2_deg_r;   cos_neg = 1'b0;
    end else if (s2_deg_r <= DEG_180) begin
      sin_idx = DEG_180 - s2_deg_r;  sin_neg = 1'b0;
      cos_idx = s2_deg_r - DEG_90;   cos_neg = 1'b1;
    end else if (s2_deg_r <= DEG_270) begin
      sin_idx = s2_deg_r - DEG_180;  sin_neg = 1'b1;
      cos_idx = DEG_270 - s2_deg_r;  cos_neg = 1'b1;
    end else begin
      sin_idx = DEG_FULL - s2_deg_r; sin_neg = 1'b1;
      cos_idx = s2_deg_r - DEG_270;  cos_neg = 1'b0;
    end
  end

  assign sin_nxt = sine_lookup(sin_idx[6:0], sin_neg);
  assign cos_nxt = sine_lookup(cos_idx[6:0], cos_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= in_mode;
    s1_pos_r  <= !in_heading[HEAD_W-1] && (in_heading != '0);
    s1_neg_r  <= in_heading[HEAD_W-1];
    s1_base_r <= base_full[BASE_W-1:0];
    s1_x_r    <= x_nxt;
    s1_q_r    <= xq_prod[RECIP360_SH +: Q360_W];

    s2_mode_r <= s1_mode_r;
    s2_pos_r  <= s1_pos_r;
    s2_neg_r  <= s1_neg_r;
    s2_base_r <= s1_base_r;
    s2_deg_r  <= rem_full[DEG_W-1:0];

    s3_mode_r <= s2_mode_r;
    s3_pos_r  <= s2_pos_r;
    s3_neg_r  <= s2_neg_r;
    s3_base_r <= s2_base_r;
    s3_sin_r  <= sin_nxt;
    s3_cos_r  <= cos_nxt;
  end

  always_comb begin
    trig.vld    = s3_vld_r;
    trig.mode   = s3_mode_r;
    trig.hd_pos = s3_pos_r;
    trig.hd_neg = s3_neg_r;
    trig.base   = s3_base_r;
    trig.sin_v  = s3_sin_r;
    trig.cos_v  = s3_cos_r;
  end

endmodule
`default_nettype wire

@@ design/mwsm_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwsm_scale
// Stages 4-6: wheel products, rounding offset and divide by 25 * 2^k.
// ----------------------------------------------------------------------------
module mwsm_scale (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mwsm_pkg::mwsm_trig_t        trig,
  input  wire logic [mwsm_pkg::GAIN_W-1:0] rotate_gain,
  output mwsm_pkg::mwsm_quo_t              quo
);
  import mwsm_pkg::*;

  // stage 4: two products; rotate uses +/-gain on both lanes
  logic signed [MULA_W-1:0] gain_s, sg, sum_cs, dif_sc, mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic                     s4_vld_r, s4_mode_r;
  logic signed [PROD_W-1:0] s4_pa_r, s4_pb_r;

  assign gain_s = $signed({{(MULA_W-GAIN_W){1'b0}}, rotate_gain});
  assign sg     = trig.hd_pos ? gain_s : (trig.hd_neg ? -gain_s : '0);
  assign sum_cs = {trig.cos_v[TRIG_W-1], trig.cos_v} + {trig.sin_v[TRIG_W-1], trig.sin_v};
  assign dif_sc = {trig.sin_v[TRIG_W-1], trig.sin_v} - {trig.cos_v[TRIG_W-1], trig.cos_v};
  assign mul_a  = (trig.mode == MODE_ROTATE) ? sg : sum_cs;
  assign mul_b  = (trig.mode == MODE_ROTATE) ? sg : dif_sc;
  assign prod_a = mul_a * trig.base;
  assign prod_b = mul_b * trig.base;

  // stage 5: |p| + D/2, then shift off the power-of-two part of D
  logic [PROD_W-1:0] mag_a, mag_b, rnd_a, rnd_b, shf_a, shf_b;
  logic              s5_vld_r, s5_mode_r, s5_nega_r, s5_negb_r;
  logic [MAG_W-1:0]  s5_ma_r, s5_mb_r;

  assign mag_a = s4_pa_r[PROD_W-1] ? $unsigned(-s4_pa_r) : $unsigned(s4_pa_r);
  assign mag_b = s4_pb_r[PROD_W-1] ? $unsigned(-s4_pb_r) : $unsigned(s4_pb_r);
  assign rnd_a = mag_a + ((s4_mode_r == MODE_ROTATE) ? ROT_HALF : TRANS_HALF);
  assign rnd_b = mag_b + ((s4_mode_r == MODE_ROTATE) ? ROT_HALF : TRANS_HALF);
  assign shf_a = (s4_mode_r == MODE_ROTATE) ? (rnd_a >> ROT_SH) : (rnd_a >> TRANS_SH);
  assign shf_b = (s4_mode_r == MODE_ROTATE) ? (rnd_b >> ROT_SH) : (rnd_b >> TRANS_SH);

  // stage 6: divide by 25 through a reciprocal (exact for 25-bit inputs)
  logic [MAG_W+RECIP25_W-1:0] div_a, div_b;
  logic                       s6_vld_r, s6_mode_r, s6_nega_r, s6_negb_r;
  logic [QUO_W-1:0]           s6_qa_r, s6_qb_r;

  assign div_a = s5_ma_r * RECIP25;
  assign div_b = s5_mb_r * RECIP25;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= trig.vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_mode_r <= trig.mode;
    s4_pa_r   <= prod_a;
    s4_pb_r   <= prod_b;

    s5_mode_r <= s4_mode_r;
    s5_nega_r <= s4_pa_r[PROD_W-1];
    s5_negb_r <= s4_pb_r[PROD_W-1];
    s5_ma_r   <= shf_a[MAG_W-1:0];
    s5_mb_r   <= shf_b[MAG_W-1:0];

    s6_mode_r <= s5_mode_r;
    s6_nega_r <= s5_nega_r;
    s6_negb_r <= s5_negb_r;
    s6_qa_r   <= div_a[RECIP25_SH +: QUO_W];
    s6_qb_r   <= div_b[RECIP25_SH +: QUO_W];
  end

  always_comb begin
    quo.vld   = s6_vld_r;
    quo.mode  = s6_mode_r;
    quo.neg_a = s6_nega_r;
    quo.neg_b = s6_negb_r;
    quo.mag_a = s6_qa_r;
    quo.mag_b = s6_qb_r;
  end

endmodule
`default_nettype wire

@@ design/mwsm_sat.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwsm_sat
// Stage 7: sign restore, wheel routing and saturation into the output regs.
// ----------------------------------------------------------------------------
module mwsm_sat #(
  parameter int SPEED_BITS = mwsm_pkg::SPEED_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mwsm_pkg::mwsm_quo_t          quo,
  output logic                              out_valid,
  output logic signed [SPEED_BITS-1:0]      out_front_left_speed,
  output logic signed [SPEED_BITS-1:0]      out_front_right_speed,
  output logic signed [SPEED_BITS-1:0]      out_back_left_speed,
  output logic signed [SPEED_BITS-1:0]      out_back_right_speed
);
  import mwsm_pkg::*;

  localparam int EXT_W = ((SPEED_BITS > VAL_W) ? SPEED_BITS : VAL_W) + 1;
  localparam logic signed [EXT_W-1:0] SAT_HI =
    $signed((EXT_W'(1) << (SPEED_BITS - 1)) - EXT_W'(1));
  localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

  function automatic logic signed [SPEED_BITS-1:0] sat(input logic signed [VAL_W-1:0] v);
    logic signed [EXT_W-1:0] w;
    logic signed [EXT_W-1:0] c;
    w = EXT_W'(v);
    if (w > SAT_HI)      c = SAT_HI;
    else if (w < SAT_LO) c = SAT_LO;
    else                 c = w;
    return c[SPEED_BITS-1:0];
  endfunction

  logic signed [VAL_W-1:0] va, vb, va_n;
  logic signed [VAL_W-1:0] fl, fr, bl;
  logic                    valid_r;
  logic signed [SPEED_BITS-1:0] fl_r, fr_r, bl_r, br_r;

  assign va   = quo.neg_a ? -$signed({2'b00, quo.mag_a}) : $signed({2'b00, quo.mag_a});
  assign vb   = quo.neg_b ? -$signed({2'b00, quo.mag_b}) : $signed({2'b00, quo.mag_b});
  assign va_n = -va;

  // rotate: left wheels -v, right wheels +v
  assign fl = (quo.mode == MODE_ROTATE) ? va_n : va;
  assign fr = (quo.mode == MODE_ROTATE) ? va   : vb;
  assign bl = (quo.mode == MODE_ROTATE) ? va_n : vb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= quo.vld;
    end
  end

  always_ff @(posedge clk) begin
    fl_r <= sat(fl);
    fr_r <= sat(fr);
    bl_r <= sat(bl);
    br_r <= sat(va);
  end

  assign out_valid             = valid_r;
  assign out_front_left_speed  = fl_r;
  assign out_front_right_speed = fr_r;
  assign out_back_left_speed   = bl_r;
  assign out_back_right_speed  = br_r;

endmodule
`default_nettype wire

@@ design/mecanum_wheel_speed_mixer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Four-wheel mecanum inverse kinematics: one drive command in, four saturated
// wheel target speeds out.
// ----------------------------------------------------------------------------
//  channel | ports                                    | handshake
//  --------+------------------------------------------+--------------------------
//  command | start, busy, in_mode/throttle/heading     | taken when start && !busy
//  result  | out_valid, out_*_speed                    | one-cycle strobe
//  config  | cfg_we, cfg_index, cfg_wdata              | written when cfg_we
//
//  Seven register stages lie between a command and its result strobe.
//  One command per cycle, limited by nothing: every stage advances each cycle.
//  busy is always low since the result side cannot push back.
//  Synchronous reset clears the stage valid bits and loads the register
//  defaults (max_speed 1000, rotate_gain 494).
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer #(
  parameter int SPEED_BITS = mwsm_pkg::SPEED_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_mode,
  input  wire logic signed [mwsm_pkg::THR_W-1:0]  in_throttle,
  input  wire logic signed [mwsm_pkg::HEAD_W-1:0] in_heading,
  output logic                                    out_valid,
  output logic signed [SPEED_BITS-1:0]            out_front_left_speed,
  output logic signed [SPEED_BITS-1:0]            out_front_right_speed,
  output logic signed [SPEED_BITS-1:0]            out_back_left_speed,
  output logic signed [SPEED_BITS-1:0]            out_back_right_speed,
  input  wire logic                               cfg_we,
  input  wire logic [mwsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwsm_pkg::CFG_W-1:0]         cfg_wdata
);
  import mwsm_pkg::*;

  logic [MAXSPD_W-1:0] max_speed_r;
  logic [GAIN_W-1:0]   rotate_gain_r;
  logic                in_vld;
  mwsm_trig_t          trig;
  mwsm_quo_t           quo;

  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= MAX_SPEED_RST;
      rotate_gain_r <= ROTATE_GAIN_RST;
    end else if (cfg_we) begin
      case (mwsm_cfg_idx_t'(cfg_index))
        CFG_MAX_SPEED:   max_speed_r   <= cfg_wdata[MAXSPD_W-1:0];
        CFG_ROTATE_GAIN: rotate_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  mwsm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_vld),
    .in_mode     (in_mode),
    .in_throttle (in_throttle),
    .in_heading  (in_heading),
    .max_speed   (max_speed_r),
    .trig        (trig)
  );

  mwsm_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .trig        (trig),
    .rotate_gain (rotate_gain_r),
    .quo         (quo)
  );

  mwsm_sat #(
    .SPEED_BITS (SPEED_BITS)
  ) u_sat (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .quo                   (quo),
    .out_valid             (out_valid),
    .out_front_left_speed  (out_front_left_speed),
    .out_front_right_speed (out_front_right_speed),
    .out_back_left_speed   (out_back_left_speed),
    .out_back_right_speed  (out_back_right_speed)
  );

endmodule
`default_nettype wire
